// ===== rtl/rms_pkg.sv =====
`default_nettype none

package rms_pkg;

  // window accumulation
  localparam int unsigned MaxWindowSamples = 1024;
  localparam int unsigned CountW = $clog2(MaxWindowSamples + 1);
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW = SampleW + 1;
  localparam int unsigned SqW = 2 * SampleW - 1;
  localparam int unsigned SumW = SqW + CountW - 1;

  // configuration
  localparam int unsigned ThrW = 31;
  localparam int unsigned LimitW = ThrW + CountW;
  localparam int unsigned SecW = 32;
  localparam int unsigned HoursW = 21;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [ThrW-1:0] ThresholdReset = ThrW'(409600);
  localparam logic [SecW-1:0] ShiftLimitReset = SecW'(28800);

  // register index, taken from paddr bit 2
  localparam logic RegThreshold = 1'b0;
  localparam logic RegShiftLimit = 1'b1;

  // seconds to hours: (x >> 4) / 225 through a reciprocal, exact for 28 bit values
  localparam int unsigned HoursPreShift = 4;
  localparam int unsigned HoursNumW = SecW - HoursPreShift;
  localparam int unsigned HoursRecipW = 29;
  localparam int unsigned HoursPostShift = 36;
  localparam logic [HoursRecipW-1:0] HoursRecip = HoursRecipW'(305419897);
  localparam int unsigned HoursProdW = HoursNumW + HoursRecipW;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      window_end;
    logic [SecW-1:0]           now_seconds;
  } in_word_t;

  typedef struct packed {
    logic              in_use;
    logic              duration_ready;
    logic [SecW-1:0]   last_duration;
    logic [SecW-1:0]   shift_seconds;
    logic [SecW-1:0]   total_seconds;
    logic [HoursW-1:0] shift_hours;
  } out_word_t;

  typedef struct packed {
    logic [ThrW-1:0] threshold_mean_square;
    logic [SecW-1:0] shift_limit_seconds;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rms_apb_regs.sv =====
`default_nettype none

module rms_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rms_pkg::AddrW-1:0]   paddr,
  input  wire logic [rms_pkg::DataW-1:0]   pwdata,
  output logic      [rms_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output rms_pkg::cfg_t                    cfg_o
);

  rms_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_mean_square <= rms_pkg::ThresholdReset;
      cfg_q.shift_limit_seconds   <= rms_pkg::ShiftLimitReset;
    end else if (wr_en) begin
      case (paddr[2])
        rms_pkg::RegThreshold: begin
          cfg_q.threshold_mean_square <= pwdata[rms_pkg::ThrW-1:0];
        end
        rms_pkg::RegShiftLimit: begin
          cfg_q.shift_limit_seconds <= pwdata[rms_pkg::SecW-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      rms_pkg::RegThreshold: begin
        prdata = rms_pkg::DataW'(cfg_q.threshold_mean_square);
      end
      rms_pkg::RegShiftLimit: begin
        prdata = rms_pkg::DataW'(cfg_q.shift_limit_seconds);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/rms_usage_runtime_meter.sv =====
// RMS threshold run-hour meter.
// Input channel: one word per ADC sample (signed sample, window_end mark,
// current time in seconds), taken at a clock edge where in_valid_i is high
// and in_stall_o is low. Squares are summed per window; the word that
// carries window_end closes the window, and only such a word yields a
// result word on the output channel (out_valid_o / out_stall_i).
// Throughput: one word per cycle when nothing stalls; the pipeline runs input
// register, squaring multiplier, accumulator, threshold multiplier
// (threshold * count), use-state update, and the output register with the
// seconds-to-hours reciprocal multiplier.
// Words that do not close a window leave the pipeline at the accumulator,
// so bubbles collapse and input keeps flowing while a result waits.
// When the receiver stalls, the output word holds and the stages behind it
// fill up; in_stall_o rises once the input register cannot move.
// Reset clears the accumulator, the use state, the start time, all run
// counters and the pipeline, and loads the default threshold and shift limit.
// Configuration goes through the APB port, register 0 (threshold) at byte
// address 0 and register 1 (shift limit) at byte address 4.
`default_nettype none

module rms_usage_runtime_meter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire rms_pkg::in_word_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output rms_pkg::out_word_t               out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rms_pkg::AddrW-1:0]   paddr,
  input  wire logic [rms_pkg::DataW-1:0]   pwdata,
  output logic      [rms_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  rms_pkg::cfg_t cfg;

  rms_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage valids and handshakes
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
  logic take_in, mv2, mv3, mv4, mv5, mvo;
  logic we2_q;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy5  = !v5_q || rdy_o;
  assign rdy4  = !v4_q || rdy5;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || !we2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign in_stall_o = !rdy1;
  assign take_in    = in_valid_i && rdy1;
  assign mv2        = v1_q && rdy2;
  assign mv3        = v2_q && we2_q && rdy3;
  assign mv4        = v3_q && rdy4;
  assign mv5        = v4_q && rdy5;
  assign mvo        = v5_q && rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q && we2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy_o) vo_q <= v5_q;
    end
  end

  // input register
  rms_pkg::in_word_t in1_q;

  always_ff @(posedge clk_i) begin
    if (take_in) in1_q <= in_data_i;
  end

  // magnitude and square
  logic [rms_pkg::MagW-1:0]     mag1;
  logic [rms_pkg::MagW-1:0]     sext1;
  logic [2*rms_pkg::MagW-1:0]   sq_full;
  logic [rms_pkg::SqW-1:0]      sq2_q;
  logic [rms_pkg::SecW-1:0]     now2_q;

  assign sext1   = {in1_q.sample[rms_pkg::SampleW-1], in1_q.sample};
  assign mag1    = in1_q.sample[rms_pkg::SampleW-1] ? (rms_pkg::MagW'(0) - sext1) : sext1;
  assign sq_full = {{rms_pkg::MagW{1'b0}}, mag1} * {{rms_pkg::MagW{1'b0}}, mag1};

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      sq2_q  <= sq_full[rms_pkg::SqW-1:0];
      we2_q  <= in1_q.window_end;
      now2_q <= in1_q.now_seconds;
    end
  end

  // window accumulator, saturates at the sample limit
  logic [rms_pkg::SumW-1:0]   acc_sum_q, sum_sel;
  logic [rms_pkg::CountW-1:0] acc_cnt_q, cnt_sel;
  logic                       acc_add;
  logic [rms_pkg::SumW-1:0]   sum3_q;
  logic [rms_pkg::CountW-1:0] cnt3_q;
  logic [rms_pkg::SecW-1:0]   now3_q;

  assign acc_add = acc_cnt_q < rms_pkg::CountW'(rms_pkg::MaxWindowSamples);
  assign sum_sel = acc_add ? acc_sum_q + rms_pkg::SumW'(sq2_q) : acc_sum_q;
  assign cnt_sel = acc_add ? acc_cnt_q + rms_pkg::CountW'(1) : acc_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q <= '0;
      acc_cnt_q <= '0;
    end else if (v2_q && rdy2) begin
      if (we2_q) begin
        acc_sum_q <= '0;
        acc_cnt_q <= '0;
      end else begin
        acc_sum_q <= sum_sel;
        acc_cnt_q <= cnt_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv3) begin
      sum3_q <= sum_sel;
      cnt3_q <= cnt_sel;
      now3_q <= now2_q;
    end
  end

  // threshold scaled by sample count
  logic [rms_pkg::LimitW-1:0] lim_d, lim4_q;
  logic [rms_pkg::SumW-1:0]   sum4_q;
  logic [rms_pkg::SecW-1:0]   now4_q;

  assign lim_d = rms_pkg::LimitW'(cfg.threshold_mean_square) * rms_pkg::LimitW'(cnt3_q);

  always_ff @(posedge clk_i) begin
    if (mv4) begin
      lim4_q <= lim_d;
      sum4_q <= sum3_q;
      now4_q <= now3_q;
    end
  end

  // use state and run counters
  logic                     use_q, use_d;
  logic [rms_pkg::SecW-1:0] start_q, start_d;
  logic [rms_pkg::SecW-1:0] period_q, period_d;
  logic [rms_pkg::SecW-1:0] shift_q, shift_d;
  logic [rms_pkg::SecW-1:0] total_q, total_d;
  logic [rms_pkg::SecW-1:0] shift_base;
  logic [rms_pkg::LimitW-1:0] sum4_ext;
  logic                     ready_d;

  assign sum4_ext = rms_pkg::LimitW'(sum4_q);

  always_comb begin
    use_d      = use_q;
    start_d    = start_q;
    period_d   = period_q;
    shift_d    = shift_q;
    total_d    = total_q;
    ready_d    = 1'b0;
    shift_base = (shift_q >= cfg.shift_limit_seconds) ? '0 : shift_q;
    if (!use_q) begin
      if (sum4_ext >= lim4_q) begin
        use_d   = 1'b1;
        start_d = now4_q;
      end
    end else if (sum4_ext <= lim4_q) begin
      use_d    = 1'b0;
      ready_d  = 1'b1;
      period_d = now4_q - start_q;
      shift_d  = shift_base + period_d;
      total_d  = total_q + period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q    <= 1'b0;
      start_q  <= '0;
      period_q <= '0;
      shift_q  <= '0;
      total_q  <= '0;
    end else if (mv5) begin
      use_q    <= use_d;
      start_q  <= start_d;
      period_q <= period_d;
      shift_q  <= shift_d;
      total_q  <= total_d;
    end
  end

  // snapshot of the window result
  logic                     use5_q, ready5_q;
  logic [rms_pkg::SecW-1:0] period5_q, shift5_q, total5_q;

  always_ff @(posedge clk_i) begin
    if (mv5) begin
      use5_q    <= use_d;
      ready5_q  <= ready_d;
      period5_q <= period_d;
      shift5_q  <= shift_d;
      total5_q  <= total_d;
    end
  end

  // shift hours by reciprocal multiply, then output register
  logic [rms_pkg::HoursProdW-1:0] hours_prod;
  rms_pkg::out_word_t             out_q;

  assign hours_prod =
    rms_pkg::HoursProdW'(shift5_q[rms_pkg::SecW-1:rms_pkg::HoursPreShift]) *
    rms_pkg::HoursProdW'(rms_pkg::HoursRecip);

  always_ff @(posedge clk_i) begin
    if (mvo) begin
      out_q.in_use         <= use5_q;
      out_q.duration_ready <= ready5_q;
      out_q.last_duration  <= period5_q;
      out_q.shift_seconds  <= shift5_q;
      out_q.total_seconds  <= total5_q;
      out_q.shift_hours    <= hours_prod[rms_pkg::HoursPostShift +: rms_pkg::HoursW];
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // checks on the pipeline and use state
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cnt_q <= rms_pkg::CountW'(rms_pkg::MaxWindowSamples))
    else $error("window count beyond limit");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.duration_ready && out_data_o.in_use))
    else $error("finished period reported while in use");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(use_q) |-> (start_q == $past(now4_q)))
    else $error("start time not taken from closing word");

  a_hold_s4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !rdy5) |=> (v4_q && $stable(lim4_q) && $stable(sum4_q)))
    else $error("threshold stage lost a word under stall");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("stall with empty input register");

endmodule

`default_nettype wire
